// File: hw/rtl/ial_pkg.sv
// ============================================================================
// ial_pkg
// Shared types, token codes and character helpers for the indent-aware lexer.
// ============================================================================
package ial_pkg;

    localparam int INDENT_DEPTH    = 16;
    localparam int INDENT_WIDTH    = 12;
    localparam int KEYWORD_MAX_LEN = 8;
    localparam int TOP_W           = $clog2(INDENT_DEPTH);
    localparam int FILL_W          = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int BUF_W           = KEYWORD_MAX_LEN * 8;

    // token kinds
    localparam logic [5:0] K_SINGLE0   = 6'd16;
    localparam logic [5:0] K_DOT       = 6'd23;
    localparam logic [5:0] K_SLASH     = 6'd29;
    localparam logic [5:0] K_ASSIGN    = 6'd30;
    localparam logic [5:0] K_EQEQ      = 6'd31;
    localparam logic [5:0] K_BANGEQ    = 6'd32;
    localparam logic [5:0] K_LESS      = 6'd33;
    localparam logic [5:0] K_LESSEQ    = 6'd34;
    localparam logic [5:0] K_GREATER   = 6'd35;
    localparam logic [5:0] K_GREATEREQ = 6'd36;
    localparam logic [5:0] K_NEWLINE   = 6'd37;
    localparam logic [5:0] K_INDENT    = 6'd38;
    localparam logic [5:0] K_DEDENT    = 6'd39;
    localparam logic [5:0] K_STRING    = 6'd40;
    localparam logic [5:0] K_NUMBER    = 6'd41;
    localparam logic [5:0] K_IDENT     = 6'd42;
    localparam logic [5:0] K_EOF       = 6'd43;
    localparam logic [5:0] K_NONE      = 6'd0;

    // error codes
    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_INDENT = 2'd1;
    localparam logic [1:0] E_STRING = 2'd2;
    localparam logic [1:0] E_BYTE   = 2'd3;

    localparam logic [3:0] TAB_RESET = 4'd4;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] tok_start;
        logic [31:0] tok_len;
        logic [31:0] tok_line;
        logic [7:0]  bad_byte;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        M_LSTART, M_NORMAL, M_IDENT, M_NUMINT, M_NUMDOT, M_NUMFRAC,
        M_STRING, M_SLASH, M_CMP, M_LCOMM, M_BLOCK, M_BSTAR
    } t_mode;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_PRE, CMD_DOT, CMD_CHECK, CMD_DEDENT,
        CMD_START, CMD_EOF, CMD_DONE
    } t_cmd;

    typedef enum logic [2:0] {
        NX_DONE, NX_START, NX_DOT, NX_CHECK, NX_EOF
    } t_next;

    typedef struct packed {
        logic  out_free;
        t_next pre_next;
        logic  grow;
        logic  more;
        logic  is_end;
        logic  pend_v;
    } t_dp_status;

    localparam logic [BUF_W-1:0] KW_TEXT [16] = '{
        BUF_W'("class"), BUF_W'("def"), BUF_W'("task"), BUF_W'("parallel"),
        BUF_W'("async"), BUF_W'("await"), BUF_W'("if"), BUF_W'("else"),
        BUF_W'("for"), BUF_W'("while"), BUF_W'("return"), BUF_W'("and"),
        BUF_W'("or"), BUF_W'("not"), BUF_W'("pass"), BUF_W'("print")
    };
    localparam logic [FILL_W-1:0] KW_LEN [16] = '{
        FILL_W'(5), FILL_W'(3), FILL_W'(4), FILL_W'(8), FILL_W'(5), FILL_W'(5),
        FILL_W'(2), FILL_W'(4), FILL_W'(3), FILL_W'(5), FILL_W'(6), FILL_W'(3),
        FILL_W'(2), FILL_W'(3), FILL_W'(4), FILL_W'(5)
    };

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alp(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // {hit, kind} for one-byte punctuation
    function automatic logic [6:0] single_kind(input logic [7:0] c);
        logic [6:0] r;
        case (c)
            "(":     r = {1'b1, 6'd16};
            ")":     r = {1'b1, 6'd17};
            "{":     r = {1'b1, 6'd18};
            "}":     r = {1'b1, 6'd19};
            "[":     r = {1'b1, 6'd20};
            "]":     r = {1'b1, 6'd21};
            ",":     r = {1'b1, 6'd22};
            ".":     r = {1'b1, 6'd23};
            ";":     r = {1'b1, 6'd24};
            ":":     r = {1'b1, 6'd25};
            "+":     r = {1'b1, 6'd26};
            "-":     r = {1'b1, 6'd27};
            "*":     r = {1'b1, 6'd28};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [BUF_W-1:0] b,
                                              input logic [FILL_W-1:0] fill);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 15; i >= 0; i--) begin
            if (fill == KW_LEN[i] && b == KW_TEXT[i]) begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

endpackage

// File: hw/rtl/ial_ctrl.sv
// ============================================================================
// ial_ctrl
// Sequencer: steps one request through its lexing phases.
// ============================================================================
module ial_ctrl
    import ial_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_st,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PRE    = 8'b0000_0010,
        S_DOT    = 8'b0000_0100,
        S_CHECK  = 8'b0000_1000,
        S_DEDENT = 8'b0001_0000,
        S_START  = 8'b0010_0000,
        S_EOF    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_state w_after;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_after    = i_st.is_end ? S_EOF : S_START;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (i_st.out_free) begin
                    o_cmd = CMD_PRE;
                    case (i_st.pre_next)
                        NX_START: n_state = S_START;
                        NX_DOT:   n_state = S_DOT;
                        NX_CHECK: n_state = S_CHECK;
                        NX_EOF:   n_state = S_EOF;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_DOT: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_DOT;
                    n_state = w_after;
                end
            end
            S_CHECK: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_CHECK;
                    n_state = i_st.grow ? w_after : S_DEDENT;
                end
            end
            S_DEDENT: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_DEDENT;
                    n_state = i_st.more ? S_DEDENT : w_after;
                end
            end
            S_START: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_START;
                    n_state = S_DONE;
                end
            end
            S_EOF: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_EOF;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd   = CMD_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/ial_dp.sv
// ============================================================================
// ial_dp
// Lexer datapath: lexer state, indent stack, result hold and output register.
// ============================================================================
module ial_dp
    import ial_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in        i_in,
    input  logic       i_cfg_valid,
    input  logic [3:0] i_cfg_data,
    input  logic       i_out_stall,
    output t_dp_status o_st,
    output logic       o_out_valid,
    output t_res       o_out
);

    logic                    r_op;
    logic [7:0]              r_ch;
    logic [3:0]              r_tab;
    t_mode                   r_mode, n_mode;
    logic [INDENT_WIDTH-1:0] r_stack [INDENT_DEPTH];
    logic [INDENT_WIDTH-1:0] n_stack [INDENT_DEPTH];
    logic [TOP_W-1:0]        r_top, n_top;
    logic [INDENT_WIDTH-1:0] r_icount, n_icount;
    logic [BUF_W-1:0]        r_buf, n_buf;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [31:0]             r_pos, n_pos, r_tbeg, n_tbeg, r_line, n_line, r_run, n_run;
    logic [7:0]              r_pend_op, n_pend_op;
    logic                    r_ws, n_ws;
    logic                    r_pv;
    t_res                    r_pend;
    logic                    r_ov;
    t_res                    r_out;

    logic                    e_v;
    logic [5:0]              e_kind;
    logic [1:0]              e_err;
    logic [31:0]             e_st, e_len;
    logic [7:0]              e_bad;

    logic [INDENT_WIDTH-1:0] w_topv;
    logic [INDENT_WIDTH:0]   w_isum;
    logic [6:0]              w_single;
    logic                    w_sp, w_grow, w_more;
    logic [5:0]              w_k1, w_k2;
    t_next                   w_pre_next;

    assign w_topv = r_stack[r_top];
    assign w_sp   = (r_ch == " ") || (r_ch == "\t");
    assign w_grow = r_icount > w_topv;
    assign w_more = (r_top != '0) && (r_icount < w_topv);
    assign w_single = single_kind(r_ch);
    assign w_isum = {1'b0, r_icount} + ((r_ch == " ") ? (INDENT_WIDTH+1)'(1)
                                                      : (INDENT_WIDTH+1)'(r_tab));

    always_comb begin
        case (r_pend_op)
            "!":     begin w_k1 = K_IDENT;   w_k2 = K_BANGEQ;    end
            "<":     begin w_k1 = K_LESS;    w_k2 = K_LESSEQ;    end
            ">":     begin w_k1 = K_GREATER; w_k2 = K_GREATEREQ; end
            default: begin w_k1 = K_ASSIGN;  w_k2 = K_EQEQ;      end
        endcase
    end

    // next phase after the mode-specific step
    always_comb begin
        w_pre_next = NX_DONE;
        if (r_op) begin
            case (r_mode)
                M_LSTART: w_pre_next = r_ws ? NX_CHECK : NX_EOF;
                M_NUMDOT: w_pre_next = NX_DOT;
                default:  w_pre_next = NX_EOF;
            endcase
        end else begin
            case (r_mode)
                M_LSTART:  w_pre_next = w_sp ? NX_DONE : NX_CHECK;
                M_IDENT:   w_pre_next = (is_alp(r_ch) || is_dig(r_ch)) ? NX_DONE : NX_START;
                M_NUMINT:  w_pre_next = (is_dig(r_ch) || r_ch == ".") ? NX_DONE : NX_START;
                M_NUMFRAC: w_pre_next = is_dig(r_ch) ? NX_DONE : NX_START;
                M_NUMDOT:  w_pre_next = is_dig(r_ch) ? NX_DONE : NX_DOT;
                M_SLASH:   w_pre_next = (r_ch == "/" || r_ch == "*") ? NX_DONE : NX_START;
                M_CMP:     w_pre_next = (r_ch == "=") ? NX_DONE : NX_START;
                M_LCOMM:   w_pre_next = (r_ch == "\n") ? NX_START : NX_DONE;
                M_NORMAL:  w_pre_next = NX_START;
                default:   w_pre_next = NX_DONE;
            endcase
        end
    end

    assign o_st.out_free = !r_ov || !i_out_stall;
    assign o_st.pre_next = w_pre_next;
    assign o_st.grow     = w_grow;
    assign o_st.more     = w_more;
    assign o_st.is_end   = r_op;
    assign o_st.pend_v   = r_pv;

    always_comb begin
        n_mode = r_mode; n_stack = r_stack; n_top = r_top; n_icount = r_icount;
        n_buf = r_buf; n_fill = r_fill; n_pos = r_pos; n_tbeg = r_tbeg;
        n_line = r_line; n_run = r_run; n_pend_op = r_pend_op; n_ws = r_ws;
        e_v = 1'b0; e_kind = K_NONE; e_err = E_NONE; e_st = r_tbeg; e_len = r_run;
        e_bad = 8'd0;
        case (i_cmd)
            CMD_PRE: begin
                if (r_op) begin
                    case (r_mode)
                        M_IDENT: begin
                            e_v = 1'b1; e_kind = ident_kind(r_buf, r_fill);
                        end
                        M_NUMINT, M_NUMFRAC, M_NUMDOT: begin
                            e_v = 1'b1; e_kind = K_NUMBER;
                        end
                        M_STRING: begin
                            e_v = 1'b1; e_err = E_STRING;
                        end
                        M_SLASH: begin
                            e_v = 1'b1; e_kind = K_SLASH; e_len = 32'd1;
                        end
                        M_CMP: begin
                            e_v = 1'b1; e_kind = w_k1; e_len = 32'd1;
                        end
                        default: ;
                    endcase
                end else begin
                    case (r_mode)
                        M_LSTART: begin
                            n_ws = 1'b1;
                            if (w_sp) begin
                                n_icount = w_isum[INDENT_WIDTH] ? '1 : w_isum[INDENT_WIDTH-1:0];
                                n_run    = sat_add(r_run, 32'd1);
                            end
                        end
                        M_IDENT: begin
                            if (is_alp(r_ch) || is_dig(r_ch)) begin
                                n_run = sat_add(r_run, 32'd1);
                                if (r_fill < FILL_W'(KEYWORD_MAX_LEN)) begin
                                    n_buf = {r_buf[BUF_W-9:0], r_ch};
                                end
                                if (r_fill <= FILL_W'(KEYWORD_MAX_LEN)) begin
                                    n_fill = r_fill + 1'b1;
                                end
                            end else begin
                                e_v = 1'b1; e_kind = ident_kind(r_buf, r_fill);
                            end
                        end
                        M_NUMINT, M_NUMFRAC: begin
                            if (is_dig(r_ch)) begin
                                n_run = sat_add(r_run, 32'd1);
                            end else if (r_mode == M_NUMINT && r_ch == ".") begin
                                n_mode = M_NUMDOT;
                            end else begin
                                e_v = 1'b1; e_kind = K_NUMBER;
                            end
                        end
                        M_NUMDOT: begin
                            if (is_dig(r_ch)) begin
                                n_run  = sat_add(r_run, 32'd2);
                                n_mode = M_NUMFRAC;
                            end else begin
                                e_v = 1'b1; e_kind = K_NUMBER;
                            end
                        end
                        M_STRING: begin
                            n_run = sat_add(r_run, 32'd1);
                            if (r_ch == "\n") begin
                                n_line = sat_add(r_line, 32'd1);
                            end
                            if (r_ch == "\"") begin
                                e_v = 1'b1; e_kind = K_STRING; e_len = n_run;
                                n_mode = M_NORMAL;
                            end
                        end
                        M_SLASH: begin
                            if (r_ch == "/") begin
                                n_mode = M_LCOMM;
                            end else if (r_ch == "*") begin
                                n_mode = M_BLOCK;
                            end else begin
                                e_v = 1'b1; e_kind = K_SLASH; e_len = 32'd1;
                            end
                        end
                        M_CMP: begin
                            if (r_ch == "=") begin
                                e_v = 1'b1; e_kind = w_k2; e_len = 32'd2;
                                n_mode = M_NORMAL;
                            end else begin
                                e_v = 1'b1; e_kind = w_k1; e_len = 32'd1;
                            end
                        end
                        M_BLOCK: begin
                            if (r_ch == "*") n_mode = M_BSTAR;
                        end
                        M_BSTAR: begin
                            if (r_ch == "/") n_mode = M_NORMAL;
                            else if (r_ch != "*") n_mode = M_BLOCK;
                        end
                        default: ;
                    endcase
                end
            end
            CMD_DOT: begin
                e_v = 1'b1; e_kind = K_DOT; e_st = sat_add(r_tbeg, r_run); e_len = 32'd1;
            end
            CMD_CHECK: begin
                if (w_grow) begin
                    e_v = 1'b1;
                    if (r_top != TOP_W'(INDENT_DEPTH - 1)) begin
                        n_top = r_top + 1'b1;
                        n_stack[r_top + 1'b1] = r_icount;
                        e_kind = K_INDENT;
                    end else begin
                        e_err = E_INDENT;
                    end
                end
            end
            CMD_DEDENT: begin
                if (w_more) begin
                    n_top = r_top - 1'b1;
                    e_v = 1'b1; e_kind = K_DEDENT;
                end else if (r_icount != w_topv) begin
                    e_v = 1'b1; e_err = E_INDENT;
                end
            end
            CMD_START: begin
                n_mode = M_NORMAL;
                if (w_single[6]) begin
                    e_v = 1'b1; e_kind = w_single[5:0]; e_st = r_pos; e_len = 32'd1;
                end else begin
                    n_tbeg = r_pos;
                    case (r_ch)
                        "/": n_mode = M_SLASH;
                        "=", "!", "<", ">": begin
                            n_mode = M_CMP; n_pend_op = r_ch;
                        end
                        " ", "\t", "\r": ;
                        "\n": begin
                            e_v = 1'b1; e_kind = K_NEWLINE; e_st = r_pos; e_len = 32'd1;
                            n_line = sat_add(r_line, 32'd1);
                            n_mode = M_LSTART; n_tbeg = sat_add(r_pos, 32'd1);
                            n_run = '0; n_icount = '0; n_ws = 1'b0;
                        end
                        "\"": begin
                            n_mode = M_STRING; n_run = 32'd1;
                        end
                        default: begin
                            if (is_dig(r_ch)) begin
                                n_mode = M_NUMINT; n_run = 32'd1;
                            end else if (is_alp(r_ch)) begin
                                n_mode = M_IDENT; n_run = 32'd1;
                                n_buf = {{(BUF_W-8){1'b0}}, r_ch}; n_fill = FILL_W'(1);
                            end else begin
                                e_v = 1'b1; e_err = E_BYTE; e_st = r_pos;
                                e_len = 32'd1; e_bad = r_ch;
                            end
                        end
                    endcase
                end
            end
            CMD_EOF: begin
                e_v = 1'b1; e_kind = K_EOF; e_st = r_pos; e_len = '0;
                n_mode = M_LSTART; n_top = '0; n_icount = '0; n_buf = '0; n_fill = '0;
                n_pos = '0; n_tbeg = '0; n_line = 32'd1; n_run = '0; n_pend_op = '0;
                n_ws = 1'b0;
            end
            CMD_DONE: begin
                if (!r_op) n_pos = sat_add(r_pos, 32'd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab <= TAB_RESET;
            r_mode <= M_LSTART; r_top <= '0; r_icount <= '0; r_buf <= '0; r_fill <= '0;
            r_pos <= '0; r_tbeg <= '0; r_line <= 32'd1; r_run <= '0; r_pend_op <= '0;
            r_ws <= 1'b0; r_pv <= 1'b0; r_ov <= 1'b0;
            for (int i = 0; i < INDENT_DEPTH; i++) r_stack[i] <= '0;
        end else begin
            if (i_cfg_valid) r_tab <= i_cfg_data;
            r_mode <= n_mode; r_stack <= n_stack; r_top <= n_top; r_icount <= n_icount;
            r_buf <= n_buf; r_fill <= n_fill; r_pos <= n_pos; r_tbeg <= n_tbeg;
            r_line <= n_line; r_run <= n_run; r_pend_op <= n_pend_op; r_ws <= n_ws;
            // output register drains independently of the hold stage
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            if (e_v) begin
                // push the held result out, hold the new one
                if (r_pv) begin
                    r_ov <= 1'b1; r_out <= r_pend; r_out.last <= 1'b0;
                end
                r_pv <= 1'b1;
            end else if (i_cmd == CMD_DONE && r_pv) begin
                r_ov <= 1'b1; r_out <= r_pend; r_out.last <= 1'b1; r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_op <= i_in.op;
            r_ch <= i_in.ch;
        end
        if (e_v) begin
            r_pend <= '{kind: e_kind, err: e_err, tok_start: e_st, tok_len: e_len,
                        tok_line: r_line, bad_byte: e_bad, last: 1'b0};
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

// File: hw/rtl/indent_aware_lexer.sv
// ============================================================================
// indent_aware_lexer
// Indentation-sensitive tokenizer: source bytes in, tokens and errors out.
// ============================================================================
// Usage:
//   Input channel i_in (op, ch) with i_in_valid / o_in_stall: one request is
//   a source byte (op 0) or the end of source (op 1). Output channel o_out
//   with o_out_valid / i_out_stall carries the tokens and errors of a request
//   (none, one or more); o_out.last marks the final result of an input request.
//   Configuration: i_cfg_valid / o_cfg_ready write tab_width (i_cfg_data),
//   always ready; write only while the block is idle.
// Sequencing:
//   One request at a time. A byte that emits nothing passes through accept,
//   mode step and finish; further phases (trailing dot, indent check, each
//   DEDENT, token start, EOF) come in between as needed, and no new request
//   is accepted until the finish phase returns the sequencer to idle. Each
//   result leaves through a one-deep hold stage, so the last result of a
//   request is written to the output register in the finish phase.
// Reset: synchronous, active low; lexer at line start, line 1, tab_width 4.
// Stall: while i_out_stall holds a full output register, the sequencer
//   freezes in any busy phase and o_in_stall stays high; no result is lost.
// ============================================================================
module indent_aware_lexer
    import ial_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_res       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    t_cmd       w_cmd;
    t_dp_status w_st;

    assign o_cfg_ready = 1'b1;

    // sequencer: owns phase order and the input handshake
    ial_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (w_st),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // datapath: lexer state, indent stack, result staging
    ial_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_st        (w_st),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // an accepted request makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block not busy after accepting a request");

    // the finish phase always returns to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd == CMD_DONE |=> !o_in_stall)
        else $error("no return to idle after finish phase");

    // nothing may stay held in the staging register while idle
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_st.pend_v)
        else $error("result left in hold stage while idle");

endmodule

// File: test/tb_indent_aware_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indent_aware_lexer
// Streams source bytes and end requests into the lexer. A built-in token
// predictor queues the expected tokens and a checker compares each result
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_indent_aware_lexer;
    import ial_pkg::*;

    localparam int LIMIT = 600000;
    localparam int SETTLE = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in        i_in = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_res       o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_data = TAB_RESET;

    indent_aware_lexer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Token predictor state
    // ------------------------------------------------------------------
    t_res        exp_tokens[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          max_gap = 12;
    int          hold_len = 0;
    int          cycles = 0;

    t_mode       lx_mode;
    logic [11:0] lx_stack[16];
    int          lx_top;
    logic [11:0] lx_cols;
    logic [31:0] lx_pos, lx_begin, lx_line, lx_run;
    int          lx_fill;
    logic [7:0]  lx_word[8];
    logic [7:0]  lx_cmp_ch;
    logic        lx_ws;
    logic [3:0]  lx_tab;
    int          step_count;

    string keywords[16] = '{"class", "def", "task", "parallel", "async", "await",
        "if", "else", "for", "while", "return", "and", "or", "not", "pass", "print"};
    string singles = "(){}[],.;:+-*";

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Queue one expected token; anything past 19 for one request is dropped.
    function automatic void put_token(logic [5:0] kind, logic [1:0] err, logic [31:0] st,
                                      logic [31:0] len, logic [7:0] bad);
        t_res r;
        if (step_count >= 19) return;
        r.kind = kind; r.err = err; r.tok_start = st; r.tok_len = len;
        r.tok_line = lx_line; r.bad_byte = bad; r.last = 1'b0;
        exp_tokens.push_back(r);
        step_count++;
    endfunction

    function automatic void clear_lexer();
        foreach (lx_stack[i]) lx_stack[i] = '0;
        foreach (lx_word[i]) lx_word[i] = '0;
        lx_top = 0; lx_cols = '0; lx_pos = '0; lx_begin = '0; lx_line = 1;
        lx_run = '0; lx_fill = 0; lx_cmp_ch = '0; lx_mode = M_LSTART; lx_ws = 1'b0;
    endfunction

    function automatic void begin_line(logic [31:0] at);
        lx_mode = M_LSTART; lx_begin = at; lx_run = '0; lx_cols = '0; lx_ws = 1'b0;
    endfunction

    // Compare the new line's columns against the indent stack.
    function automatic void judge_indent();
        if (lx_cols > lx_stack[lx_top]) begin
            if (lx_top + 1 < INDENT_DEPTH) begin
                lx_top++;
                lx_stack[lx_top] = lx_cols;
                put_token(K_INDENT, E_NONE, lx_begin, lx_run, 0);
            end else begin
                put_token(K_NONE, E_INDENT, lx_begin, lx_run, 0);
            end
            return;
        end
        while (lx_top > 0 && lx_cols < lx_stack[lx_top]) begin
            lx_top--;
            put_token(K_DEDENT, E_NONE, lx_begin, lx_run, 0);
        end
        if (lx_cols != lx_stack[lx_top]) put_token(K_NONE, E_INDENT, lx_begin, lx_run, 0);
    endfunction

    function automatic logic [5:0] word_kind();
        logic hit;
        if (lx_fill <= KEYWORD_MAX_LEN) begin
            for (int i = 0; i < 16; i++) begin
                hit = (keywords[i].len() == lx_fill);
                for (int j = 0; j < keywords[i].len() && hit; j++)
                    if (keywords[i][j] != lx_word[j]) hit = 1'b0;
                if (hit) return 6'(i);
            end
        end
        return K_IDENT;
    endfunction

    function automatic void flush_cmp(logic paired);
        logic [5:0] k1, k2;
        case (lx_cmp_ch)
            "!":     begin k1 = K_IDENT;   k2 = K_BANGEQ;    end
            "<":     begin k1 = K_LESS;    k2 = K_LESSEQ;    end
            ">":     begin k1 = K_GREATER; k2 = K_GREATEREQ; end
            default: begin k1 = K_ASSIGN;  k2 = K_EQEQ;      end
        endcase
        put_token(paired ? k2 : k1, E_NONE, lx_begin, paired ? 2 : 1, 0);
    endfunction

    function automatic void open_token(logic [7:0] c, logic [31:0] p);
        lx_mode = M_NORMAL;
        for (int i = 0; i < singles.len(); i++)
            if (singles[i] == c) begin
                put_token(K_SINGLE0 + 6'(i), E_NONE, p, 1, 0);
                return;
            end
        lx_begin = p;
        case (c)
            "/": begin lx_mode = M_SLASH; return; end
            "=", "!", "<", ">": begin lx_mode = M_CMP; lx_cmp_ch = c; return; end
            " ", 8'h09, 8'h0d: return;
            8'h0a: begin
                put_token(K_NEWLINE, E_NONE, p, 1, 0);
                lx_line = add_sat(lx_line, 1);
                begin_line(add_sat(p, 1));
                return;
            end
            "\"": begin lx_mode = M_STRING; lx_run = 1; return; end
            default: ;
        endcase
        if (c >= "0" && c <= "9") begin
            lx_mode = M_NUMINT; lx_run = 1;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
            lx_mode = M_IDENT; lx_run = 1; lx_word[0] = c; lx_fill = 1;
        end else begin
            put_token(K_NONE, E_BYTE, p, 1, c);
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic [31:0] p);
        logic dig, alp;
        dig = c >= "0" && c <= "9";
        alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        case (lx_mode)
            M_LSTART: begin
                lx_ws = 1'b1;
                if (c == " " || c == 8'h09) begin
                    int sum;
                    sum = int'(lx_cols) + ((c == " ") ? 1 : int'(lx_tab));
                    lx_cols = (sum > 4095) ? 12'hFFF : 12'(sum);
                    lx_run = add_sat(lx_run, 1);
                end else begin
                    judge_indent();
                    open_token(c, p);
                end
            end
            M_IDENT: begin
                if (alp || dig) begin
                    lx_run = add_sat(lx_run, 1);
                    if (lx_fill < KEYWORD_MAX_LEN) lx_word[lx_fill] = c;
                    if (lx_fill <= KEYWORD_MAX_LEN) lx_fill++;
                end else begin
                    put_token(word_kind(), E_NONE, lx_begin, lx_run, 0);
                    open_token(c, p);
                end
            end
            M_NUMINT, M_NUMFRAC: begin
                if (dig) lx_run = add_sat(lx_run, 1);
                else if (lx_mode == M_NUMINT && c == ".") lx_mode = M_NUMDOT;
                else begin
                    put_token(K_NUMBER, E_NONE, lx_begin, lx_run, 0);
                    open_token(c, p);
                end
            end
            M_NUMDOT: begin
                if (dig) begin
                    lx_run = add_sat(lx_run, 2); lx_mode = M_NUMFRAC;
                end else begin
                    put_token(K_NUMBER, E_NONE, lx_begin, lx_run, 0);
                    put_token(K_DOT, E_NONE, add_sat(lx_begin, lx_run), 1, 0);
                    open_token(c, p);
                end
            end
            M_STRING: begin
                lx_run = add_sat(lx_run, 1);
                if (c == 8'h0a) lx_line = add_sat(lx_line, 1);
                if (c == "\"") begin
                    put_token(K_STRING, E_NONE, lx_begin, lx_run, 0);
                    lx_mode = M_NORMAL;
                end
            end
            M_SLASH: begin
                if (c == "/") lx_mode = M_LCOMM;
                else if (c == "*") lx_mode = M_BLOCK;
                else begin
                    put_token(K_SLASH, E_NONE, lx_begin, 1, 0);
                    open_token(c, p);
                end
            end
            M_CMP: begin
                if (c == "=") begin
                    flush_cmp(1'b1); lx_mode = M_NORMAL;
                end else begin
                    flush_cmp(1'b0); open_token(c, p);
                end
            end
            M_LCOMM: if (c == 8'h0a) open_token(c, p);
            M_BLOCK: if (c == "*") lx_mode = M_BSTAR;
            M_BSTAR: begin
                if (c == "/") lx_mode = M_NORMAL;
                else if (c != "*") lx_mode = M_BLOCK;
            end
            default: open_token(c, p);
        endcase
    endfunction

    function automatic void lex_end();
        case (lx_mode)
            M_LSTART: if (lx_ws) judge_indent();
            M_IDENT: put_token(word_kind(), E_NONE, lx_begin, lx_run, 0);
            M_NUMINT, M_NUMFRAC: put_token(K_NUMBER, E_NONE, lx_begin, lx_run, 0);
            M_NUMDOT: begin
                put_token(K_NUMBER, E_NONE, lx_begin, lx_run, 0);
                put_token(K_DOT, E_NONE, add_sat(lx_begin, lx_run), 1, 0);
            end
            M_STRING: put_token(K_NONE, E_STRING, lx_begin, lx_run, 0);
            M_SLASH: put_token(K_SLASH, E_NONE, lx_begin, 1, 0);
            M_CMP: flush_cmp(1'b0);
            default: ;
        endcase
        put_token(K_EOF, E_NONE, lx_pos, 0, 0);
        clear_lexer();
    endfunction

    // Work out the tokens of one accepted request and tag the final one.
    function automatic void predict_tokens(logic op, logic [7:0] c);
        step_count = 0;
        if (op) begin
            lex_end();
        end else begin
            lex_byte(c, lx_pos);
            lx_pos = add_sat(lx_pos, 1);
        end
        if (step_count > 0) exp_tokens[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Send one request; hold valid high across back-to-back requests.
    task automatic send_item(logic op, logic [7:0] c);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{op: op, ch: c};
        do @(posedge i_clk); while (o_in_stall);
        predict_tokens(op, c);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    // Drop valid, drain every expected token, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (exp_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tab_width(logic [3:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lx_tab = v;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per result, plus an optional long hold
    // ------------------------------------------------------------------
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            n = $urandom_range(0, max_gap);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall) && hold_len == 0);
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_tokens.size() == 0) begin
                report("unexpected token kind", o_out.kind, -1);
            end else begin
                w = exp_tokens.pop_front();
                if (o_out.kind != w.kind) report("kind", o_out.kind, w.kind);
                if (o_out.err != w.err) report("err", o_out.err, w.err);
                if (o_out.tok_start != w.tok_start) report("tok_start", o_out.tok_start, w.tok_start);
                if (o_out.tok_len != w.tok_len) report("tok_len", o_out.tok_len, w.tok_len);
                if (o_out.tok_line != w.tok_line) report("tok_line", o_out.tok_line, w.tok_line);
                if (o_out.bad_byte != w.bad_byte) report("bad_byte", o_out.bad_byte, w.bad_byte);
                if (o_out.last != w.last) report("last", o_out.last, w.last);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_indent_aware_lexer NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_keywords();
        send_text("class def task parallel async await if else for while return ");
        send_text("and or not pass print parallelx print9 _Z\n");
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_operators();
        // lone bang, pairs, bad bytes (all-zero and all-one bytes included)
        send_text("(){}[],.;:+-*/a = == != ! < <= > >= @");
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_text("x=");
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_numbers();
        send_text("12.5 7. 3.x 9");
        send_item(1'b1, 8'h00);
        send_text("4.");
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_indentation();
        // indent, tab, blank line, dedent, inconsistent dedent, end after newline
        send_text("a\n    b\n\tc\n\n  d\ne\n");
        send_item(1'b1, 8'h00);
        send_text("q\n   ");
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_strings_comments();
        // multi-line string, line comment, block comment hiding a newline
        send_text("\"ab\ncd\" // x\n/* y\n**/z /\"open");
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_deep_indent();
        // one level deeper per line until the stack overflows, then pop all
        for (int k = 1; k <= INDENT_DEPTH; k++) begin
            for (int j = 0; j < k; j++) send_item(1'b0, 8'h09);
            send_text("x\n");
        end
        send_text("y\n");
        send_item(1'b1, 8'h00);
    endtask

    task automatic random_line();
        int r, n;
        string s;
        r = $urandom_range(0, 9);
        if (r < 4) n = lx_stack[$urandom_range(0, lx_top)];
        else if (r < 7) n = lx_stack[lx_top] + $urandom_range(1, 4);
        else n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_item(1'b0, ($urandom_range(0, 4) == 0) ? 8'h09 : " ");
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 9))
                0: s = keywords[$urandom_range(0, 15)];
                1: begin
                    s = "";
                    repeat ($urandom_range(1, 10))
                        s = {s, string'(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                                              : "0" + $urandom_range(0, 9)))};
                    s = {"v", s};
                end
                2: s = ($urandom_range(0, 1)) ? "42" : "3.14";
                3: s = ($urandom_range(0, 1)) ? "== " : "!";
                4: s = "<=>(";
                5: s = "\"s t\"";
                6: s = "/* c */";
                7: s = " + ";
                8: s = "// note";
                default: s = string'(8'($urandom_range(0, 255)));
            endcase
            send_text(s);
            send_item(1'b0, " ");
        end
        send_item(1'b0, 8'h0a);
    endtask

    task automatic test_random(int target);
        int stop;
        stop = items_sent + target;
        while (items_sent < stop) begin
            random_line();
            if ($urandom_range(0, 7) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
        end
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_backpressure();
        // hold the receiver while requests keep coming so the lexer stalls its input
        hold_len = 400;
        max_gap = 0;
        send_text("if a >= 10:\n    return b.c\n");
        send_item(1'b1, 8'h00);
        max_gap = 12;
    endtask

    initial begin
        lx_tab = TAB_RESET;
        clear_lexer();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_keywords();
        test_operators();
        test_numbers();
        test_indentation();
        test_strings_comments();
        write_tab_width(4'd1);
        test_deep_indent();
        write_tab_width(4'd15);
        test_indentation();
        test_backpressure();
        test_random(60);
        write_tab_width(4'($urandom_range(1, 15)));
        max_gap = 0;
        test_random(40);
        max_gap = 12;
        write_tab_width(4'd4);
        test_random(70);

        drain();
        if (fail_count == 0) begin
            $display("tb_indent_aware_lexer OK");
        end else begin
            $display("tb_indent_aware_lexer NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ial_pkg.sv
hw/rtl/ial_ctrl.sv
hw/rtl/ial_dp.sv
hw/rtl/indent_aware_lexer.sv
test/tb_indent_aware_lexer.sv
